// ===== rtl/rbei_pkg.sv =====
// shared types, operation codes and fixed point helpers for the rigid body integrator
// no dependencies; imported by every module of the block
`default_nettype none

package rbei_pkg;

	typedef enum logic [2:0] {
		FUNC_ADD_FORCE  = 3'd0,
		FUNC_ADD_TORQUE = 3'd1,
		FUNC_INTEGRATE  = 3'd2,
		FUNC_SET_POS    = 3'd3,
		FUNC_SET_ORIENT = 3'd4,
		FUNC_SET_VEL    = 3'd5,
		FUNC_SET_SPIN   = 3'd6,
		FUNC_NOP        = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		REG_GRAVITY_X  = 3'd0,
		REG_GRAVITY_Y  = 3'd1,
		REG_GRAVITY_Z  = 3'd2,
		REG_INV_MASS   = 3'd3,
		REG_INV_INERT  = 3'd4,
		REG_LIN_DAMP   = 3'd5,
		REG_ANG_DAMP   = 3'd6,
		REG_IS_STATIC  = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		LS_IDLE,
		LS_DAMP_L,
		LS_DAMP_A,
		LS_POS,
		LS_ORI,
		LS_ACC,
		LS_ALPHA,
		LS_VEL,
		LS_SPIN,
		LS_DIV_GO,
		LS_DIV_WAIT
	} lane_state_t;

	typedef struct packed {
		logic [30:0] inv_mass;
		logic [30:0] inv_inertia;
		logic [30:0] lin_damp;
		logic [30:0] ang_damp;
		logic        is_static;
	} lane_cfg_t;

	typedef struct packed {
		logic        start;
		func_t       func;
		logic [30:0] dt;
	} lane_cmd_t;

	typedef struct packed {
		logic busy;
	} lane_stat_t;

	localparam int unsigned QONE      = 65536;
	localparam int unsigned DIVISOR_W = 47;
	localparam int unsigned NUM_W     = 48;

	function automatic logic signed [51:0] sx52(input logic signed [31:0] v);
		return {{20{v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
		logic signed [51:0] hi;
		logic signed [51:0] lo;
		hi = 52'sh0_0000_7FFF_FFFF;
		lo = 52'shF_FFFF_8000_0000;
		if (x > hi)
			return 32'sh7FFF_FFFF;
		else if (x < lo)
			return 32'sh8000_0000;
		else
			return x[31:0];
	endfunction

	// floor((p + 2^15) / 2^16)
	function automatic logic signed [49:0] rnd_q(input logic signed [65:0] p);
		logic signed [65:0] t;
		t = p + 66'sd32768;
		return $signed(t[65:16]);
	endfunction

	function automatic logic signed [31:0] sat_rnd(input logic signed [65:0] p);
		logic signed [49:0] r;
		r = rnd_q(p);
		return sat32({{2{r[49]}}, r});
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rigid_body_euler_integrator_top.sv =====
// top level: apb register file, three component lanes and the merging output register
// uses rbei_pkg, rbei_lane (which uses rbei_div)
//
// channel   dir  signals                      request contents
// s_*       in   s_tvalid s_tready s_tdata    one operation with vector and step
//                s_tuser
// m_*       out  m_tvalid m_tready m_tdata    full body state after the operation
// apb       in   psel penable pwrite paddr    register writes and reads
//                pwdata prdata pready
//
// set and add operations: the result loads into the output register once that is free;
// the next request is taken after that load; integrate does the same after 8 chained
// products on each lane's single multiplier, then the restoring dividers for damping
// a new request is taken while a finished result waits in the output register
// reset clears config, control and body state, not output data; inverse mass and inertia reset to 1.0
`default_nettype none

module rigid_body_euler_integrator_top
	import rbei_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	input  wire logic [127:0] s_tdata,   // vec_x, vec_y, vec_z, time_step, pad
	input  wire logic [2:0]   s_tuser,   // func
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	output      logic [383:0] m_tdata,   // pos_x..z, orient_x..z, vel_x..z, spin_x..z
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output      logic [31:0]  prdata,
	output      logic         pready
);

	logic signed [31:0] grav_q [3];
	lane_cfg_t          cfg_q;
	logic               busy_q;
	logic               out_valid_q;
	logic [383:0]       out_data_q;
	logic               accept, lanes_busy, load;
	lane_cmd_t          cmd;
	lane_stat_t         stat [3];
	logic signed [31:0] pos [3], ori [3], vel [3], spin [3];
	reg_idx_t           ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q[0]         <= '0;
			grav_q[1]         <= '0;
			grav_q[2]         <= '0;
			cfg_q.inv_mass    <= 31'(QONE);
			cfg_q.inv_inertia <= 31'(QONE);
			cfg_q.lin_damp    <= '0;
			cfg_q.ang_damp    <= '0;
			cfg_q.is_static   <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_GRAVITY_X: grav_q[0]         <= pwdata;
				REG_GRAVITY_Y: grav_q[1]         <= pwdata;
				REG_GRAVITY_Z: grav_q[2]         <= pwdata;
				REG_INV_MASS:  cfg_q.inv_mass    <= pwdata[30:0];
				REG_INV_INERT: cfg_q.inv_inertia <= pwdata[30:0];
				REG_LIN_DAMP:  cfg_q.lin_damp    <= pwdata[30:0];
				REG_ANG_DAMP:  cfg_q.ang_damp    <= pwdata[30:0];
				REG_IS_STATIC: cfg_q.is_static   <= pwdata[0];
				default: begin end
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_GRAVITY_X: prdata = grav_q[0];
			REG_GRAVITY_Y: prdata = grav_q[1];
			REG_GRAVITY_Z: prdata = grav_q[2];
			REG_INV_MASS:  prdata = {1'b0, cfg_q.inv_mass};
			REG_INV_INERT: prdata = {1'b0, cfg_q.inv_inertia};
			REG_LIN_DAMP:  prdata = {1'b0, cfg_q.lin_damp};
			REG_ANG_DAMP:  prdata = {1'b0, cfg_q.ang_damp};
			REG_IS_STATIC: prdata = {31'b0, cfg_q.is_static};
			default:       prdata = '0;
		endcase
	end

	assign s_tready  = !busy_q;
	assign accept    = s_tvalid && s_tready;
	assign cmd.start = accept;
	assign cmd.func  = func_t'(s_tuser);
	assign cmd.dt    = s_tdata[126:96];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		rbei_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.cfg     (cfg_q),
			.gravity (grav_q[i]),
			.vec     (s_tdata[32*i +: 32]),
			.stat    (stat[i]),
			.pos     (pos[i]),
			.orient  (ori[i]),
			.vel     (vel[i]),
			.spin    (spin[i])
		);
	end

	assign lanes_busy = stat[0].busy || stat[1].busy || stat[2].busy;
	assign load       = busy_q && !lanes_busy && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (load)
				busy_q <= 1'b0;
			if (load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// merge the three lanes into one state record
	always_ff @(posedge clk) begin
		if (load)
			out_data_q <= {spin[2], spin[1], spin[0], vel[2], vel[1], vel[0],
				ori[2], ori[1], ori[0], pos[2], pos[1], pos[0]};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		stat[0].busy == stat[1].busy && stat[1].busy == stat[2].busy)
		else $error("lanes out of lockstep");

	idle_means_lanes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !lanes_busy)
		else $error("lane busy while top idle");

	result_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(busy_q))
		else $error("result without a request");

endmodule

`default_nettype wire

// ===== rtl/rbei_div.sv =====
// restoring divider, one quotient bit per cycle, 32 quotient bits
// uses rbei_pkg for widths; the numerator must be below 2^32 times the divisor
`default_nettype none

module rbei_div
	import rbei_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NUM_W-1:0]     num,
	input  wire logic [DIVISOR_W-1:0] den,
	output      logic                 busy,
	output      logic [31:0]          quot
);

	logic [NUM_W-1:0]     rem_q;
	logic [31:0]          lo_q;
	logic [31:0]          quot_q;
	logic [DIVISOR_W-1:0] den_q;
	logic [4:0]           cnt_q;
	logic                 busy_q;
	logic [NUM_W-1:0]     trial;
	logic                 fits;

	assign trial = {rem_q[NUM_W-2:0], lo_q[31]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {{(NUM_W-16){1'b0}}, num[NUM_W-1:32]};
			lo_q   <= num[31:0];
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? trial - {1'b0, den_q} : trial;
			lo_q   <= {lo_q[30:0], 1'b0};
			quot_q <= {quot_q[30:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

// ===== rtl/rbei_lane.sv =====
// one vector component of the body state with its own multiplier sequencer and two dividers
// uses rbei_pkg and rbei_div
`default_nettype none

module rbei_lane
	import rbei_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lane_cmd_t          cmd,
	input  wire lane_cfg_t          cfg,
	input  wire logic signed [31:0] gravity,
	input  wire logic signed [31:0] vec,
	output      lane_stat_t         stat,
	output      logic signed [31:0] pos,
	output      logic signed [31:0] orient,
	output      logic signed [31:0] vel,
	output      logic signed [31:0] spin
);

	lane_state_t state_q, state_d;

	logic signed [31:0] pos_q, ori_q, vel_q, spin_q, force_q, torque_q;
	logic signed [31:0] acc_q, alpha_q, vn_q, wn_q;
	logic [30:0]        dt_q;
	logic [DIVISOR_W-1:0] dl_q, da_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [49:0] prod_r;
	logic signed [31:0] prod_s;

	logic [31:0]      mag_v, mag_w, qv, qw;
	logic [NUM_W-1:0] num_v, num_w;
	logic             dv_busy, dw_busy, div_go;
	logic             div_go_v, div_go_w, go_q;

	assign prod_r = rnd_q(prod_q);
	assign prod_s = sat_rnd(prod_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			LS_DAMP_L: begin mul_a = {2'b0, dt_q}; mul_b = {2'b0, cfg.lin_damp}; end
			LS_DAMP_A: begin mul_a = {2'b0, dt_q}; mul_b = {2'b0, cfg.ang_damp}; end
			LS_POS:    begin mul_a = {vel_q[31], vel_q}; mul_b = {2'b0, dt_q}; end
			LS_ORI:    begin mul_a = {spin_q[31], spin_q}; mul_b = {2'b0, dt_q}; end
			LS_ACC:    begin mul_a = {force_q[31], force_q}; mul_b = {2'b0, cfg.inv_mass}; end
			LS_ALPHA:  begin mul_a = {torque_q[31], torque_q}; mul_b = {2'b0, cfg.inv_inertia}; end
			LS_VEL:    begin mul_a = {acc_q[31], acc_q}; mul_b = {2'b0, dt_q}; end
			LS_SPIN:   begin mul_a = {alpha_q[31], alpha_q}; mul_b = {2'b0, dt_q}; end
			default: begin end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LS_IDLE:
				if (cmd.start && cmd.func == FUNC_INTEGRATE && !cfg.is_static)
					state_d = LS_DAMP_L;
			LS_DAMP_L:   state_d = LS_DAMP_A;
			LS_DAMP_A:   state_d = LS_POS;
			LS_POS:      state_d = LS_ORI;
			LS_ORI:      state_d = LS_ACC;
			LS_ACC:      state_d = LS_ALPHA;
			LS_ALPHA:    state_d = LS_VEL;
			LS_VEL:      state_d = LS_SPIN;
			LS_SPIN:     state_d = LS_DIV_GO;
			LS_DIV_GO:   state_d = LS_DIV_WAIT;
			LS_DIV_WAIT: if (!go_q && !dv_busy && !dw_busy) state_d = LS_IDLE;
			default:     state_d = LS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= LS_IDLE;
		else
			state_q <= state_d;
	end

	// product of the previous step lands in prod_q, the step after consumes it
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == LS_IDLE && cmd.start)
			dt_q <= cmd.dt;
		if (state_q == LS_DAMP_A)
			dl_q <= DIVISOR_W'(QONE) + prod_r[DIVISOR_W-1:0];
		if (state_q == LS_POS)
			da_q <= DIVISOR_W'(QONE) + prod_r[DIVISOR_W-1:0];
		if (state_q == LS_ALPHA)
			acc_q <= sat32(sx52(gravity) + sx52(prod_s));
		if (state_q == LS_VEL)
			alpha_q <= prod_s;
		if (state_q == LS_SPIN)
			vn_q <= sat32(sx52(vel_q) + sx52(prod_s));
		if (state_q == LS_DIV_GO)
			wn_q <= sat32(sx52(spin_q) + sx52(prod_s));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ori_q    <= '0;
			vel_q    <= '0;
			spin_q   <= '0;
			force_q  <= '0;
			torque_q <= '0;
		end else begin
			if (state_q == LS_IDLE && cmd.start) begin
				case (cmd.func)
					FUNC_ADD_FORCE:  force_q  <= sat32(sx52(force_q) + sx52(vec));
					FUNC_ADD_TORQUE: torque_q <= sat32(sx52(torque_q) + sx52(vec));
					FUNC_SET_POS:    pos_q    <= vec;
					FUNC_SET_ORIENT: ori_q    <= vec;
					FUNC_SET_VEL:    vel_q    <= vec;
					FUNC_SET_SPIN:   spin_q   <= vec;
					default: begin end
				endcase
			end
			if (state_q == LS_ORI)
				pos_q <= sat32(sx52(pos_q) + sx52(prod_s));
			if (state_q == LS_ACC)
				ori_q <= sat32(sx52(ori_q) + sx52(prod_s));
			if (state_q == LS_DIV_WAIT && !go_q && !dv_busy && !dw_busy) begin
				vel_q    <= vn_q[31] ? -$signed(qv) : $signed(qv);
				spin_q   <= wn_q[31] ? -$signed(qw) : $signed(qw);
				force_q  <= '0;
				torque_q <= '0;
			end
		end
	end

	// dividers start after the last product, via LS_DIV_GO and the go_q register, so both operands are registered
	assign div_go = (state_q == LS_DIV_GO);
	assign mag_v  = vn_q[31] ? 32'(-vn_q) : 32'(vn_q);
	assign mag_w  = wn_q[31] ? 32'(-wn_q) : 32'(wn_q);
	// numerator is |v|*2^16 + d/2
	assign num_v  = {mag_v, 16'b0} + {2'b0, dl_q[DIVISOR_W-1:1]};
	assign num_w  = {mag_w, 16'b0} + {2'b0, da_q[DIVISOR_W-1:1]};

	rbei_div u_div_v (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_v),
		.num    (num_v),
		.den    (dl_q),
		.busy   (dv_busy),
		.quot   (qv)
	);

	rbei_div u_div_w (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_w),
		.num    (num_w),
		.den    (da_q),
		.busy   (dw_busy),
		.quot   (qw)
	);

	// wn_q is written at the div_go edge, so the dividers launch the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			go_q <= 1'b0;
		else
			go_q <= div_go;
	end
	assign div_go_v = go_q;
	assign div_go_w = go_q;

	assign stat.busy = (state_q != LS_IDLE);
	assign pos    = pos_q;
	assign orient = ori_q;
	assign vel    = vel_q;
	assign spin   = spin_q;

	unused_sink: assert property (@(posedge clk) disable iff (!arst_n)
		dv_busy == dw_busy)
		else $error("lane dividers out of step");

	wait_holds: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == LS_DIV_GO) |-> state_q == LS_DIV_WAIT && !dv_busy && go_q)
		else $error("divider launch misplaced");

	idle_at_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == LS_DIV_WAIT && !dv_busy && !dw_busy && !go_q) |->
		state_q == LS_IDLE && force_q == 0 && torque_q == 0)
		else $error("integrate commit did not clear sums");

endmodule

`default_nettype wire
